// ----- hw/rtl/subpage_chunk_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sub-page chunk allocator
// Concurrent check wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SUBPAGE_CHUNK_ALLOCATOR_DEFINES_SVH
`define SUBPAGE_CHUNK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/sca_pkg.sv -----
// ----------------------------------------------------------------------------
// Sub-page chunk allocator package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int PAGE_BITS       = 20;
  localparam logic [6:0] LIMIT_RESET = 7'd64;
  localparam logic [3:0] ALL_FREE = 4'hf;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_SPARE     = 3'd1,
    ST_FULL         = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_ALREADY_FREE = 3'd4,
    ST_BAD_RANGE    = 3'd5
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [2:0]           chunk_count;
    logic [PAGE_BITS-1:0] page_number;
    logic [1:0]           chunk_index;
    logic                 spare_valid;
  } in_req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [PAGE_BITS-1:0] result_page;
    logic [1:0]           result_chunk;
    logic                 spare_taken;
    logic                 page_released;
  } out_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD, S_WAIT, S_EVAL, S_APPEND, S_SHRD, S_SHWAIT, S_SHWR, S_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic idx_first;
    logic idx_step;
    logic rd;
    logic upd_entry;
    logic append;
    logic sh_wr;
    logic shrink;
    logic miss;
    logic respond;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bad;
    logic scan_end;
    logic hit;
    logic dup_free;
    logic shift_end;
    logic release_pg;
    logic free_mode;
    logic append_ok;
  } sts_t;

  function automatic logic [3:0] run_mask(input logic [1:0] first, input logic [2:0] count);
    logic [4:0] m;
    begin
      m = ((5'd1 << count) - 5'd1) << first;
      run_mask = m[3:0];
    end
  endfunction

  // Lowest start of a free run; bit 2 set means none.
  function automatic logic [2:0] find_run(input logic [3:0] map, input logic [2:0] count);
    logic [2:0] r;
    logic [3:0] m;
    begin
      r = 3'd4;
      for (int s = 3; s >= 0; s--) begin
        m = run_mask(2'(s), count);
        if ((3'(s) + count <= 3'd4) && ((map & m) == m)) r = 3'(s);
      end
      find_run = r;
    end
  endfunction

endpackage

// ----- hw/rtl/subpage_chunk_allocator.sv -----
// ----------------------------------------------------------------------------
// Sub-page chunk allocator
// First-fit allocator over quarter-page chunks of a compacted page table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with out_strobe, which the receiver cannot stall.
// The table sits in one single-port RAM, so each scanned entry passes through
// read, RAM wait and evaluate states and each entry moved down after a page
// release passes through read, wait and write states. A free that releases
// a page moves every later entry of the table down by one. A new request
// can be taken in the cycle that carries the strobe.
module subpage_chunk_allocator #(
  parameter int TABLE_DEPTH = sca_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sca_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output sca_pkg::out_res_t out_res,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata
);

  sca_pkg::cmd_t cmd;
  sca_pkg::sts_t sts;

  sca_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .sts(sts), .cmd(cmd)
  );

  sca_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .sts(sts), .out_strobe(out_strobe), .out_res(out_res)
  );

endmodule

// ----- hw/rtl/sca_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/sca_datapath.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Holds the request, the entry count, the scan index and the table RAM.
// ----------------------------------------------------------------------------
`include "subpage_chunk_allocator_defines.svh"
module sca_datapath #(
  parameter int TABLE_DEPTH = sca_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sca_pkg::in_req_t in_req,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata,
  input  sca_pkg::cmd_t    cmd,
  output sca_pkg::sts_t    sts,
  output logic             out_strobe,
  output sca_pkg::out_res_t out_res
);

  localparam int PAGE_BITS = sca_pkg::PAGE_BITS;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = PAGE_BITS + 4;

  sca_pkg::in_req_t req_r;
  logic [6:0]  limit_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [PAGE_BITS-1:0] pg_r, pg_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic        tk_r, tk_nxt, rl_r, rl_nxt;
  logic        strobe_r;
  logic [AW-1:0] addr;
  logic          we;
  logic [DW-1:0] wdata, rdata;
  logic [PAGE_BITS-1:0] rd_page, req_page;
  logic [3:0]  rd_map, fmask, newmap;
  logic [2:0]  run;
  logic        is_alloc;
  logic [CW-1:0] lim;

  assign rd_page  = rdata[DW-1:4];
  assign rd_map   = rdata[3:0];
  assign req_page = req_r.page_number;
  assign is_alloc = (req_r.mode == sca_pkg::MODE_ALLOC);
  assign run      = sca_pkg::find_run(rd_map, req_r.chunk_count);
  assign fmask    = sca_pkg::run_mask(req_r.chunk_index, req_r.chunk_count);
  assign newmap   = rd_map | fmask;
  assign lim = (32'(limit_r) < TABLE_DEPTH) ? CW'(limit_r) : CW'(TABLE_DEPTH);

  // Status back to the controller.
  always_comb begin
    sts.bad = (req_r.chunk_count == 3'd0) || (req_r.chunk_count > 3'd4) ||
              (!is_alloc && ({1'b0, req_r.chunk_index} + req_r.chunk_count > 3'd4));
    sts.scan_end   = is_alloc ? (idx_r == used_r) : (idx_r == '0);
    sts.hit        = is_alloc ? !run[2] : (rd_page == req_page);
    sts.dup_free   = !is_alloc && ((rd_map & fmask) != 4'd0);
    sts.shift_end  = (idx_r >= used_r);
    sts.release_pg = (newmap == sca_pkg::ALL_FREE);
    sts.free_mode  = !is_alloc;
    sts.append_ok  = is_alloc && (used_r < lim) && req_r.spare_valid;
  end

  // RAM address and write data.
  always_comb begin
    addr  = idx_r[AW-1:0];
    we    = 1'b0;
    wdata = rdata;
    if (cmd.upd_entry) begin
      we = 1'b1;
      wdata = {rd_page, is_alloc ? (rd_map & ~sca_pkg::run_mask(run[1:0], req_r.chunk_count))
                                 : newmap};
    end else if (cmd.append) begin
      we = 1'b1;
      addr = used_r[AW-1:0];
      wdata = {req_page, sca_pkg::ALL_FREE & ~sca_pkg::run_mask(2'd0, req_r.chunk_count)};
    end else if (cmd.sh_wr) begin
      we = 1'b1;
      addr = AW'(idx_r - CW'(1));
    end
  end

  sca_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Index, count and result next values.
  always_comb begin
    idx_nxt = idx_r; used_nxt = used_r;
    st_nxt = st_r; pg_nxt = pg_r; ch_nxt = ch_r; tk_nxt = tk_r; rl_nxt = rl_r;
    if (cmd.capture) begin
      st_nxt = sca_pkg::ST_BAD_RANGE; pg_nxt = '0; ch_nxt = '0; tk_nxt = 1'b0; rl_nxt = 1'b0;
    end
    if (cmd.idx_first) idx_nxt = is_alloc ? '0 : used_r;
    if (cmd.idx_step) idx_nxt = (is_alloc || cmd.sh_wr) ? idx_r + CW'(1) : idx_r - CW'(1);
    // Error outcome for a request that found no entry and cannot append.
    if (cmd.miss) begin
      if (is_alloc)
        st_nxt = (used_r >= lim) ? sca_pkg::ST_FULL : sca_pkg::ST_NO_SPARE;
      else st_nxt = sca_pkg::ST_NOT_FOUND;
    end
    if (cmd.upd_entry) begin
      st_nxt = sca_pkg::ST_OK; pg_nxt = rd_page;
      if (is_alloc) ch_nxt = run[1:0];
      else if (sts.release_pg) idx_nxt = idx_r + CW'(1);
    end
    if (cmd.rd && sts.hit && sts.dup_free)
      st_nxt = sca_pkg::ST_ALREADY_FREE;
    if (cmd.append) begin
      st_nxt = sca_pkg::ST_OK; pg_nxt = req_page; tk_nxt = 1'b1; used_nxt = used_r + CW'(1);
    end
    if (cmd.shrink) begin
      rl_nxt = 1'b1; used_nxt = used_r - CW'(1);
    end
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sca_pkg::LIMIT_RESET;
      used_r <= '0; idx_r <= '0; strobe_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      used_r <= used_nxt; idx_r <= idx_nxt; strobe_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_req;
    st_r <= st_nxt; pg_r <= pg_nxt; ch_r <= ch_nxt; tk_r <= tk_nxt; rl_r <= rl_nxt;
  end

  // Result port.
  assign out_strobe = strobe_r;
  always_comb begin
    out_res.status = st_r;
    out_res.result_page = (st_r == sca_pkg::ST_OK) ? pg_r : '0;
    out_res.result_chunk = (st_r == sca_pkg::ST_OK) ? ch_r : '0;
    out_res.spare_taken = (st_r == sca_pkg::ST_OK) && tk_r;
    out_res.page_released = (st_r == sca_pkg::ST_OK) && rl_r;
  end

  `SCA_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= CW'(TABLE_DEPTH), "entry count overflow")
  `SCA_ASSERT_IMP(a_one_write, clk, rst_n, 1'b1, $onehot0({cmd.upd_entry, cmd.append, cmd.sh_wr}), "two table writes")
  `SCA_ASSERT_NXT(a_append_grow, clk, rst_n, cmd.append, used_r == $past(used_r) + CW'(1), "append lost")

endmodule

// ----- hw/rtl/sca_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences validate, scan, update, append and shift-down for one request.
// ----------------------------------------------------------------------------
`include "subpage_chunk_allocator_defines.svh"
module sca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sca_pkg::sts_t sts,
  output sca_pkg::cmd_t cmd
);

  sca_pkg::state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sca_pkg::S_IDLE: if (start) state_nxt = sca_pkg::S_CHECK;
      sca_pkg::S_CHECK: begin
        if (sts.bad) state_nxt = sca_pkg::S_DONE;
        else state_nxt = sca_pkg::S_RD;
      end
      sca_pkg::S_RD: begin
        if (sts.scan_end) state_nxt = sts.append_ok ? sca_pkg::S_APPEND : sca_pkg::S_DONE;
        else state_nxt = sca_pkg::S_WAIT;
      end
      sca_pkg::S_WAIT: state_nxt = sca_pkg::S_EVAL;
      sca_pkg::S_EVAL: begin
        if (!sts.hit) state_nxt = sca_pkg::S_RD;
        else if (sts.dup_free) state_nxt = sca_pkg::S_DONE;
        else if (sts.free_mode && sts.release_pg) state_nxt = sca_pkg::S_SHRD;
        else state_nxt = sca_pkg::S_DONE;
      end
      sca_pkg::S_APPEND: state_nxt = sca_pkg::S_DONE;
      sca_pkg::S_SHRD: state_nxt = sts.shift_end ? sca_pkg::S_DONE : sca_pkg::S_SHWAIT;
      sca_pkg::S_SHWAIT: state_nxt = sca_pkg::S_SHWR;
      sca_pkg::S_SHWR: state_nxt = sca_pkg::S_SHRD;
      sca_pkg::S_DONE: state_nxt = sca_pkg::S_IDLE;
      default: state_nxt = sca_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    busy = (state_r != sca_pkg::S_IDLE);
    unique case (state_r)
      sca_pkg::S_IDLE: cmd.capture = start;
      sca_pkg::S_CHECK: cmd.idx_first = 1'b1;
      sca_pkg::S_RD: begin
        cmd.miss = sts.scan_end && !sts.append_ok;
        if (!sts.scan_end && sts.free_mode) cmd.idx_step = 1'b1;
      end
      sca_pkg::S_WAIT: ;
      sca_pkg::S_EVAL: begin
        cmd.rd = 1'b1;
        cmd.upd_entry = sts.hit && !sts.dup_free;
        if (!sts.hit && !sts.free_mode) cmd.idx_step = 1'b1;
      end
      sca_pkg::S_APPEND: cmd.append = 1'b1;
      sca_pkg::S_SHRD: cmd.shrink = sts.shift_end;
      sca_pkg::S_SHWAIT: ;
      sca_pkg::S_SHWR: begin
        cmd.sh_wr = 1'b1;
        cmd.idx_step = 1'b1;
      end
      sca_pkg::S_DONE: cmd.respond = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sca_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SCA_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "request not taken")
  `SCA_ASSERT_NXT(a_done_idle, clk, rst_n, state_r == sca_pkg::S_DONE, !busy, "done did not finish")
  `SCA_ASSERT_IMP(a_resp_once, clk, rst_n, cmd.respond, busy, "response while idle")

endmodule

// ----- tb/subpage_chunk_allocator_checker.sv -----
// ----------------------------------------------------------------------------
// Sub-page chunk allocator checker
// Watches the request, result and configuration ports, keeps its own copy
// of the page table, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module subpage_chunk_allocator_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  sca_pkg::in_req_t  in_req,
  input  logic              out_strobe,
  input  sca_pkg::out_res_t out_res,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  output int                fail_count,
  output int                pending_count
);

  localparam int DEPTH = 64;

  // Shadow copy of the page table and the limit register.
  logic [19:0] shadow_page [DEPTH];
  logic [3:0]  shadow_map [DEPTH];
  int          shadow_used;
  logic [6:0]  shadow_limit;

  sca_pkg::out_res_t expected_results [$];

  // Mask of count chunks starting at first, clipped to the page.
  function automatic logic [3:0] chunk_mask(input int first, input int count);
    logic [7:0] m;
    m = ((8'd1 << count) - 8'd1) << first;
    return m[3:0];
  endfunction

  // Lowest start of a free run of count chunks, or 4 when there is none.
  function automatic int lowest_free_run(input logic [3:0] map, input int count);
    for (int s = 0; s + count <= 4; s++) begin
      if ((map & chunk_mask(s, count)) == chunk_mask(s, count)) return s;
    end
    return 4;
  endfunction

  // Applies one request to the shadow table and returns its result.
  function automatic sca_pkg::out_res_t apply_request(input sca_pkg::in_req_t r);
    sca_pkg::out_res_t res;
    int cnt, cidx, lim, s, e;
    logic [3:0] m;
    res = '0;
    cnt = r.chunk_count;
    cidx = r.chunk_index;
    if (cnt == 0 || cnt > 4) begin
      res.status = sca_pkg::ST_BAD_RANGE;
      return res;
    end
    if (r.mode == sca_pkg::MODE_ALLOC) begin
      lim = (shadow_limit < DEPTH) ? shadow_limit : DEPTH;
      for (int i = 0; i < shadow_used; i++) begin
        s = lowest_free_run(shadow_map[i], cnt);
        if (s < 4) begin
          shadow_map[i] &= ~chunk_mask(s, cnt);
          res.status = sca_pkg::ST_OK;
          res.result_page = shadow_page[i];
          res.result_chunk = s[1:0];
          return res;
        end
      end
      if (shadow_used >= lim) begin
        res.status = sca_pkg::ST_FULL;
      end else if (!r.spare_valid) begin
        res.status = sca_pkg::ST_NO_SPARE;
      end else begin
        shadow_page[shadow_used] = r.page_number;
        shadow_map[shadow_used] = sca_pkg::ALL_FREE & ~chunk_mask(0, cnt);
        shadow_used++;
        res.status = sca_pkg::ST_OK;
        res.result_page = r.page_number;
        res.spare_taken = 1'b1;
      end
      return res;
    end
    if (cidx + cnt > 4) begin
      res.status = sca_pkg::ST_BAD_RANGE;
      return res;
    end
    // Free: the newest entry holding the page wins.
    for (e = shadow_used - 1; e >= 0; e--) begin
      if (shadow_page[e] == r.page_number) break;
    end
    if (e < 0) begin
      res.status = sca_pkg::ST_NOT_FOUND;
      return res;
    end
    m = chunk_mask(cidx, cnt);
    if ((shadow_map[e] & m) != 4'd0) begin
      res.status = sca_pkg::ST_ALREADY_FREE;
      return res;
    end
    shadow_map[e] |= m;
    res.status = sca_pkg::ST_OK;
    res.result_page = r.page_number;
    if (shadow_map[e] == sca_pkg::ALL_FREE) begin
      for (int j = e; j + 1 < shadow_used; j++) begin
        shadow_page[j] = shadow_page[j + 1];
        shadow_map[j] = shadow_map[j + 1];
      end
      shadow_used--;
      res.page_released = 1'b1;
    end
    return res;
  endfunction

  // Compares one result against the oldest prediction.
  always @(posedge clk) begin
    sca_pkg::out_res_t want;
    if (!rst_n) begin
      shadow_used = 0;
      shadow_limit = sca_pkg::LIMIT_RESET;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_res != want) fail_count <= fail_count + 1;
          if (out_res.status != want.status)
            $error("status: expected %0d, got %0d", want.status, out_res.status);
          if (out_res.result_page != want.result_page)
            $error("result_page: expected %h, got %h", want.result_page,
                   out_res.result_page);
          if (out_res.result_chunk != want.result_chunk)
            $error("result_chunk: expected %0d, got %0d", want.result_chunk,
                   out_res.result_chunk);
          if (out_res.spare_taken != want.spare_taken)
            $error("spare_taken: expected %0d, got %0d", want.spare_taken,
                   out_res.spare_taken);
          if (out_res.page_released != want.page_released)
            $error("page_released: expected %0d, got %0d", want.page_released,
                   out_res.page_released);
        end
      end
      if (cfg_we) shadow_limit = cfg_wdata;
      if (start && !busy) expected_results.push_back(apply_request(in_req));
    end
  end

  assign pending_count = expected_results.size();

endmodule

// ----- tb/subpage_chunk_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Sub-page chunk allocator testbench
// Drives directed and random allocate and free requests with random gaps
// and table limit changes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module subpage_chunk_allocator_tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_REQUESTS = 850;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  sca_pkg::in_req_t  in_req = '0;
  logic              out_strobe;
  sca_pkg::out_res_t out_res;
  logic              cfg_we = 1'b0;
  logic [6:0]        cfg_wdata = '0;
  int                fail_count;
  int                pending_count;
  int                cycle_count = 0;
  int                status_seen [8];
  int                released_count = 0;
  bit                no_gaps = 0;

  // Live allocations, used to build well-formed free requests.
  logic [19:0] live_page [$];
  logic [1:0]  live_chunk [$];
  logic [2:0]  live_count [$];
  logic [19:0] page_pool [12];

  subpage_chunk_allocator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  subpage_chunk_allocator_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("subpage_chunk_allocator_tb failed");
      $finish;
    end
  end

  // Random idle time, mostly short with an occasional long stretch.
  task automatic idle_gap();
    int n;
    if (no_gaps) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    repeat (n) @(posedge clk);
  endtask

  // Sends one request, waits for its result and tracks live allocations.
  task automatic send_request(input sca_pkg::in_req_t r);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    do @(posedge clk); while (!out_strobe);
    status_seen[out_res.status]++;
    if (out_res.page_released) released_count++;
    if (r.mode == sca_pkg::MODE_ALLOC && out_res.status == sca_pkg::ST_OK) begin
      live_page.push_back(out_res.result_page);
      live_chunk.push_back(out_res.result_chunk);
      live_count.push_back(r.chunk_count);
    end
    idle_gap();
  endtask

  task automatic send_fields(input logic m, input int cnt, input logic [19:0] pg,
                             input int cidx, input logic spare);
    sca_pkg::in_req_t r;
    r.mode = m;
    r.chunk_count = cnt[2:0];
    r.page_number = pg;
    r.chunk_index = cidx[1:0];
    r.spare_valid = spare;
    send_request(r);
  endtask

  // Writes the limit register while the block is idle.
  task automatic write_limit(input logic [6:0] v);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Builds one random request, mostly well formed.
  task automatic random_request();
    sca_pkg::in_req_t r;
    int k, sel;
    r = '0;
    sel = $urandom_range(0, 99);
    r.page_number = ($urandom_range(0, 9) == 0) ? 20'($urandom) :
                    page_pool[$urandom_range(0, 11)];
    r.chunk_index = 2'($urandom);
    r.chunk_count = 3'($urandom_range(1, 4));
    r.spare_valid = ($urandom_range(0, 9) != 0);
    if (sel < 5) begin
      r = sca_pkg::in_req_t'($urandom);
    end else if (sel < 55) begin
      r.mode = sca_pkg::MODE_ALLOC;
    end else begin
      r.mode = sca_pkg::MODE_FREE;
      if (live_page.size() > 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, live_page.size() - 1);
        r.page_number = live_page[k];
        r.chunk_index = live_chunk[k];
        r.chunk_count = live_count[k];
        live_page.delete(k);
        live_chunk.delete(k);
        live_count.delete(k);
      end
    end
    send_request(r);
  endtask

  initial begin
    for (int i = 0; i < 12; i++) page_pool[i] = 20'($urandom);
    page_pool[0] = 20'h00000;
    page_pool[1] = 20'hfffff;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes and each corner case.
    send_fields(sca_pkg::MODE_ALLOC, 1, 20'h00000, 0, 1'b0);   // no spare page
    send_fields(sca_pkg::MODE_ALLOC, 0, 20'h12345, 0, 1'b1);   // bad count
    send_fields(sca_pkg::MODE_ALLOC, 7, 20'h12345, 3, 1'b1);
    send_fields(sca_pkg::MODE_FREE, 5, 20'h12345, 0, 1'b1);
    send_fields(sca_pkg::MODE_ALLOC, 1, 20'h00000, 0, 1'b1);
    send_fields(sca_pkg::MODE_ALLOC, 2, 20'hfffff, 0, 1'b1);
    send_fields(sca_pkg::MODE_ALLOC, 4, 20'hfffff, 0, 1'b1);   // no run of four, appends page
    send_fields(sca_pkg::MODE_ALLOC, 3, 20'h55555, 0, 1'b1);
    send_fields(sca_pkg::MODE_FREE, 2, 20'h00000, 3, 1'b0);    // free past page end
    send_fields(sca_pkg::MODE_FREE, 1, 20'h00000, 1, 1'b0);    // frees chunk 1
    send_fields(sca_pkg::MODE_FREE, 1, 20'h77777, 0, 1'b0);    // page not found
    send_fields(sca_pkg::MODE_FREE, 4, 20'hfffff, 0, 1'b0);    // page released
    send_fields(sca_pkg::MODE_FREE, 1, 20'h00000, 0, 1'b0);    // frees chunk 0, no release
    send_fields(sca_pkg::MODE_FREE, 2, 20'hfffff, 0, 1'b0);
    write_limit(7'd1);
    send_fields(sca_pkg::MODE_ALLOC, 4, 20'haaaaa, 0, 1'b1);   // table full
    write_limit(7'd0);
    send_fields(sca_pkg::MODE_ALLOC, 1, 20'haaaaa, 0, 1'b1);   // limit of zero
    send_fields(sca_pkg::MODE_ALLOC, 1, 20'haaaaa, 0, 1'b1);   // still searched
    write_limit(7'd127);
    send_fields(sca_pkg::MODE_ALLOC, 1, 20'h0f0f0, 0, 1'b1);
    send_fields(sca_pkg::MODE_FREE, 1, 20'h0f0f0, 0, 1'b1);
    live_page.delete();
    live_chunk.delete();
    live_count.delete();

    // Random part with limit changes between phases.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 120 == 0) begin
        case ($urandom_range(0, 5))
          0: write_limit(7'd64);
          1: write_limit(7'd1);
          2: write_limit(7'd127);
          3: write_limit(7'd0);
          4: write_limit(7'd4);
          default: write_limit(7'($urandom_range(2, 63)));
        endcase
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      random_request();
    end

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d ok, %0d no spare, %0d full, %0d not found, %0d double free,",
             status_seen[sca_pkg::ST_OK], status_seen[sca_pkg::ST_NO_SPARE],
             status_seen[sca_pkg::ST_FULL], status_seen[sca_pkg::ST_NOT_FOUND],
             status_seen[sca_pkg::ST_ALREADY_FREE]);
    $display("  %0d bad range results and %0d page releases.",
             status_seen[sca_pkg::ST_BAD_RANGE], released_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("subpage_chunk_allocator_tb passed");
    end else begin
      $display("subpage_chunk_allocator_tb failed");
    end
    $finish;
  end

endmodule
